@@ hw/rtl/fra_pkg.sv @@
// Shared field width, request codes and status codes of the region allocator.
package fra_pkg;

    localparam int FIELD_W = 21;

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;

    localparam req_t REQ_ALLOC      = 2'd0;
    localparam req_t REQ_FREE       = 2'd1;
    localparam req_t REQ_FREE_ABOVE = 2'd2;
    localparam req_t REQ_QUERY      = 2'd3;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NO_MEMORY  = 2'd1;
    localparam status_t ST_NO_REGION  = 2'd2;
    localparam status_t ST_TABLE_FULL = 2'd3;

endpackage

@@ hw/rtl/first_fit_region_allocator.sv @@
// A request goes from idle through a scan pass, a decide state and, if a table changes, a write pass to done.
// Free-above adds one scan, decide and write pass per region moved after the first
// (up to USED_SLOTS moves), then ends on one more scan pass and decide state.
// The block takes one request at a time; the rotating slot rings set the pass length.
// Query, failed alloc and free, and zero-size requests take one scan pass or none.
// Reset (aresetn low, synchronous): free slot 0 holds the whole memory, all else empty.
// Top level of the first-fit region allocator.
module first_fit_region_allocator #(
    parameter int MEM_BYTES  = 1048576,
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // amount[20:0], position[41:21], zero pad
    input  fra_pkg::req_t        s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [87:0]          m_tdata,   // granted_position[20:0], region_size[41:21],
                                            // free_total[62:42], used_total[83:63], zero pad
    output fra_pkg::status_t     m_tuser    // status[1:0]
);

    import fra_pkg::*;

    localparam int MW   = $clog2(MEM_BYTES + 1);
    localparam int AW   = (MW > FIELD_W) ? MW : FIELD_W;
    localparam int EW   = 1 + 2 * AW;
    localparam int NMAX = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
    localparam int CW   = $clog2(NMAX + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    req_t          req_reg, req_next;
    logic [AW-1:0] amt_reg, amt_next, bnd_reg, bnd_next;
    logic          f_hit_reg, f_hit_next, u_hit_reg, u_hit_next;
    logic [CW-1:0] f_sel_reg, f_sel_next, u_sel_reg, u_sel_next;
    logic [AW-1:0] f_pos_reg, f_pos_next, f_size_reg, f_size_next;
    logic [AW-1:0] u_pos_reg, u_pos_next, u_size_reg, u_size_next;
    logic [EW-1:0] f_new_reg, f_new_next, u_new_reg, u_new_next;
    status_t       status_reg, status_next;
    logic [AW-1:0] granted_reg, granted_next, rsize_reg, rsize_next;
    logic [AW-1:0] free_bytes_reg, free_bytes_next, used_bytes_reg, used_bytes_next;

    logic          f_shift, u_shift, running, last_step;
    logic [EW-1:0] f_tail, u_tail, f_head, u_head;
    logic          ft_v, ut_v;
    logic [AW-1:0] ft_pos, ft_size, ut_pos, ut_size;

    assign running   = (state_reg == S_SCAN) || (state_reg == S_WRITE);
    assign f_shift   = running && (step_reg < CW'(FREE_SLOTS));
    assign u_shift   = running && (step_reg < CW'(USED_SLOTS));
    assign last_step = (step_reg == CW'(NMAX - 1));

    assign {ft_v, ft_pos, ft_size} = f_tail;
    assign {ut_v, ut_pos, ut_size} = u_tail;

    assign f_head = (state_reg == S_WRITE && step_reg == f_sel_reg) ? f_new_reg : f_tail;
    assign u_head = (state_reg == S_WRITE && step_reg == u_sel_reg) ? u_new_reg : u_tail;

    fra_ring #(.N(FREE_SLOTS), .W(EW)) u_free_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (f_shift),
        .init0   ({1'b1, AW'(0), AW'(MEM_BYTES)}),
        .head    (f_head),
        .tail    (f_tail)
    );

    fra_ring #(.N(USED_SLOTS), .W(EW)) u_used_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (u_shift),
        .init0   ({EW{1'b0}}),
        .head    (u_head),
        .tail    (u_tail)
    );

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        req_next        = req_reg;
        amt_next        = amt_reg;
        bnd_next        = bnd_reg;
        f_hit_next      = f_hit_reg;
        f_sel_next      = f_sel_reg;
        f_pos_next      = f_pos_reg;
        f_size_next     = f_size_reg;
        u_hit_next      = u_hit_reg;
        u_sel_next      = u_sel_reg;
        u_pos_next      = u_pos_reg;
        u_size_next     = u_size_reg;
        f_new_next      = f_new_reg;
        u_new_next      = u_new_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        rsize_next      = rsize_reg;
        free_bytes_next = free_bytes_reg;
        used_bytes_next = used_bytes_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next     = s_tuser;
                    amt_next     = AW'(s_tdata[FIELD_W-1:0]);
                    bnd_next     = AW'(s_tdata[2*FIELD_W-1:FIELD_W]);
                    status_next  = ST_OK;
                    granted_next = '0;
                    rsize_next   = '0;
                    f_hit_next   = 1'b0;
                    u_hit_next   = 1'b0;
                    step_next    = '0;
                    if (s_tuser == REQ_ALLOC && s_tdata[FIELD_W-1:0] == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (f_shift) begin
                    if (req_reg == REQ_ALLOC) begin
                        if (ft_v && ft_size >= amt_reg && (!f_hit_reg || ft_pos <= f_pos_reg)) begin
                            f_hit_next  = 1'b1;
                            f_sel_next  = step_reg;
                            f_pos_next  = ft_pos;
                            f_size_next = ft_size;
                        end
                    end else if (!ft_v) begin
                        f_hit_next = 1'b1;
                        f_sel_next = step_reg;
                    end
                end
                if (u_shift) begin
                    case (req_reg)
                        REQ_ALLOC: begin
                            if (!ut_v) begin
                                u_hit_next = 1'b1;
                                u_sel_next = step_reg;
                            end
                        end
                        REQ_FREE_ABOVE: begin
                            if (ut_v && ut_pos >= bnd_reg && (!u_hit_reg || ut_pos <= u_pos_reg)) begin
                                u_hit_next  = 1'b1;
                                u_sel_next  = step_reg;
                                u_pos_next  = ut_pos;
                                u_size_next = ut_size;
                            end
                        end
                        default: begin
                            if (ut_v && ut_pos == bnd_reg) begin
                                u_hit_next  = 1'b1;
                                u_sel_next  = step_reg;
                                u_pos_next  = ut_pos;
                                u_size_next = ut_size;
                            end
                        end
                    endcase
                end
                if (last_step) begin
                    step_next  = '0;
                    state_next = S_DECIDE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (req_reg == REQ_ALLOC) begin
                    if (!f_hit_reg || !u_hit_reg) begin
                        status_next = ST_NO_MEMORY;
                    end else begin
                        f_new_next      = {(f_size_reg != amt_reg), f_pos_reg + amt_reg,
                                           f_size_reg - amt_reg};
                        u_new_next      = {1'b1, f_pos_reg, amt_reg};
                        granted_next    = f_pos_reg;
                        used_bytes_next = used_bytes_reg + amt_reg;
                        free_bytes_next = free_bytes_reg - amt_reg;
                        state_next      = S_WRITE;
                    end
                end else if (req_reg == REQ_QUERY) begin
                    if (!u_hit_reg) begin
                        status_next = ST_NO_REGION;
                    end else begin
                        rsize_next = u_size_reg;
                    end
                end else begin
                    if (!u_hit_reg) begin
                        if (req_reg == REQ_FREE) begin
                            status_next = ST_NO_REGION;
                        end
                    end else if (!f_hit_reg) begin
                        status_next = ST_TABLE_FULL;
                    end else begin
                        f_new_next      = {1'b1, u_pos_reg, u_size_reg};
                        u_new_next      = {1'b0, u_pos_reg, u_size_reg};
                        used_bytes_next = used_bytes_reg - u_size_reg;
                        free_bytes_next = free_bytes_reg + u_size_reg;
                        state_next      = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (last_step) begin
                    step_next  = '0;
                    f_hit_next = 1'b0;
                    u_hit_next = 1'b0;
                    state_next = (req_reg == REQ_FREE_ABOVE) ? S_SCAN : S_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            f_hit_reg      <= 1'b0;
            u_hit_reg      <= 1'b0;
            free_bytes_reg <= AW'(MEM_BYTES);
            used_bytes_reg <= '0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            f_hit_reg      <= f_hit_next;
            u_hit_reg      <= u_hit_next;
            free_bytes_reg <= free_bytes_next;
            used_bytes_reg <= used_bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        amt_reg     <= amt_next;
        bnd_reg     <= bnd_next;
        f_sel_reg   <= f_sel_next;
        f_pos_reg   <= f_pos_next;
        f_size_reg  <= f_size_next;
        u_sel_reg   <= u_sel_next;
        u_pos_reg   <= u_pos_next;
        u_size_reg  <= u_size_next;
        f_new_reg   <= f_new_next;
        u_new_reg   <= u_new_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        rsize_reg   <= rsize_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0, used_bytes_reg[FIELD_W-1:0], free_bytes_reg[FIELD_W-1:0],
                       rsize_reg[FIELD_W-1:0], granted_reg[FIELD_W-1:0]};

endmodule

@@ hw/rtl/fra_cell.sv @@
// One table slot of the region ring: holds an entry and passes it on when shifted.
module fra_cell #(
    parameter int W = 51
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         shift,
    input  logic [W-1:0] init,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= init;
        end else if (shift) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

@@ hw/rtl/fra_ring.sv @@
// Chain of slot cells forming a rotating region table; the tail feeds back via the head.
module fra_ring #(
    parameter int N = 16,
    parameter int W = 51
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         shift,
    input  logic [W-1:0] init0,
    input  logic [W-1:0] head,
    output logic [W-1:0] tail
);

    logic [W-1:0] link [N+1];

    assign link[0] = head;

    for (genvar k = 0; k < N; k++) begin : g_cell
        fra_cell #(.W(W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (shift),
            .init    ((k == 0) ? init0 : {W{1'b0}}),
            .d       (link[k]),
            .q       (link[k+1])
        );
    end

    assign tail = link[N];

endmodule

@@ hw/rtl/fra_check.sv @@
// Port-level checks of the region allocator, bound to its top level.
module fra_check #(
    parameter int MEM_BYTES = 1048576
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [1:0]  m_tuser
);

    import fra_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("request taken while a result is pending");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("more than one result beat for a request");

    a_fields_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[41:0] == '0)
        else $error("granted position or size reported on a failed request");

    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> FIELD_W'(m_tdata[62:42] + m_tdata[83:63]) == FIELD_W'(MEM_BYTES))
        else $error("free and used totals do not cover the memory");

endmodule

bind first_fit_region_allocator fra_check #(.MEM_BYTES(MEM_BYTES)) u_fra_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb_first_fit_region_allocator.sv @@
// Testbench of the first-fit region allocator: directed and random requests checked against a table model.
`timescale 1ns / 100ps

module tb_first_fit_region_allocator;
    import fra_pkg::*;

    localparam int MEM_BYTES  = 1048576;
    localparam int FREE_SLOTS = 16;
    localparam int USED_SLOTS = 16;
    localparam int N_ITEMS    = 1800;
    localparam int WATCHDOG   = 20000;

    typedef struct packed {
        status_t           status;
        logic [FIELD_W-1:0] granted;
        logic [FIELD_W-1:0] rsize;
        logic [FIELD_W-1:0] free_total;
        logic [FIELD_W-1:0] used_total;
    } alloc_result_t;

    class region_scoreboard;
        bit                  f_vld [FREE_SLOTS];
        logic [31:0]         f_pos [FREE_SLOTS];
        logic [31:0]         f_sz  [FREE_SLOTS];
        bit                  u_vld [USED_SLOTS];
        logic [31:0]         u_pos [USED_SLOTS];
        logic [31:0]         u_sz  [USED_SLOTS];
        logic [31:0]         used_bytes;
        alloc_result_t       pending[$];
        int                  errors;
        logic [20:0]         live_starts[$];

        function void clear();
            for (int i = 0; i < FREE_SLOTS; i++) begin
                f_vld[i] = 0; f_pos[i] = 0; f_sz[i] = 0;
            end
            for (int i = 0; i < USED_SLOTS; i++) begin
                u_vld[i] = 0; u_pos[i] = 0; u_sz[i] = 0;
            end
            f_vld[0] = 1;
            f_sz[0] = MEM_BYTES;
            used_bytes = 0;
            errors = 0;
        endfunction

        function bit release_slot(int u);
            for (int f = 0; f < FREE_SLOTS; f++) begin
                if (!f_vld[f]) begin
                    f_vld[f] = 1; f_pos[f] = u_pos[u]; f_sz[f] = u_sz[u];
                    used_bytes -= u_sz[u];
                    u_vld[u] = 0;
                    return 1;
                end
            end
            return 0;
        endfunction

        function int find_used(logic [31:0] p);
            for (int i = 0; i < USED_SLOTS; i++)
                if (u_vld[i] && u_pos[i] == p) return i;
            return -1;
        endfunction

        function void note_request(req_t req, logic [20:0] amount, logic [20:0] position);
            alloc_result_t r;
            int best, u, low;
            logic [31:0] fsum;
            r = '0;
            r.status = ST_OK;
            case (req)
                REQ_ALLOC: begin
                    if (amount != 0) begin
                        best = -1; u = -1;
                        for (int i = USED_SLOTS - 1; i >= 0; i--)
                            if (!u_vld[i]) u = i;
                        for (int i = 0; i < FREE_SLOTS; i++)
                            if (f_vld[i] && f_sz[i] >= amount &&
                                (best < 0 || f_pos[i] < f_pos[best])) best = i;
                        if (best < 0 || u < 0) begin
                            r.status = ST_NO_MEMORY;
                        end else begin
                            r.granted = f_pos[best][20:0];
                            u_vld[u] = 1; u_pos[u] = f_pos[best]; u_sz[u] = 32'(amount);
                            used_bytes += amount;
                            f_pos[best] += amount;
                            f_sz[best] -= amount;
                            if (f_sz[best] == 0) f_vld[best] = 0;
                        end
                    end
                end
                REQ_FREE: begin
                    u = find_used(32'(position));
                    if (u < 0) r.status = ST_NO_REGION;
                    else if (!release_slot(u)) r.status = ST_TABLE_FULL;
                end
                REQ_FREE_ABOVE: begin
                    for (int n = 0; n < USED_SLOTS; n++) begin
                        low = -1;
                        for (int i = 0; i < USED_SLOTS; i++)
                            if (u_vld[i] && u_pos[i] >= position &&
                                (low < 0 || u_pos[i] < u_pos[low])) low = i;
                        if (low < 0) break;
                        if (!release_slot(low)) begin
                            r.status = ST_TABLE_FULL;
                            break;
                        end
                    end
                end
                default: begin
                    u = find_used(32'(position));
                    if (u < 0) r.status = ST_NO_REGION;
                    else r.rsize = u_sz[u][20:0];
                end
            endcase
            fsum = 0;
            for (int i = 0; i < FREE_SLOTS; i++)
                if (f_vld[i]) fsum += f_sz[i];
            r.free_total = fsum[20:0];
            r.used_total = used_bytes[20:0];
            live_starts.delete();
            for (int i = 0; i < USED_SLOTS; i++)
                if (u_vld[i]) live_starts = {live_starts, u_pos[i][20:0]};
            pending = {pending, r};
        endfunction

        function void check_result(status_t st, logic [87:0] data);
            alloc_result_t e;
            if (pending.size() == 0) begin
                $error("result beat with no request pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st != e.status) begin
                $error("status: expected %0d, got %0d", e.status, st); errors++;
            end
            if (data[20:0] != e.granted) begin
                $error("granted_position: expected %0d, got %0d", e.granted, data[20:0]);
                errors++;
            end
            if (data[41:21] != e.rsize) begin
                $error("region_size: expected %0d, got %0d", e.rsize, data[41:21]);
                errors++;
            end
            if (data[62:42] != e.free_total) begin
                $error("free_total: expected %0d, got %0d", e.free_total, data[62:42]);
                errors++;
            end
            if (data[83:63] != e.used_total) begin
                $error("used_total: expected %0d, got %0d", e.used_total, data[83:63]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    req_t        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    status_t     m_tuser;

    region_scoreboard regions;
    bit  hold_sink;
    int  idle_cycles;

    first_fit_region_allocator #(
        .MEM_BYTES (MEM_BYTES),
        .FREE_SLOTS(FREE_SLOTS),
        .USED_SLOTS(USED_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    task automatic send_request(req_t req, logic [20:0] amount, logic [20:0] position);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, position, amount};
        do @(posedge aclk); while (!s_tready);
        regions.note_request(req, amount, position);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (regions.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [20:0] pick_start();
        if (regions.live_starts.size() != 0 && $urandom_range(0, 4) != 0)
            return regions.live_starts[$urandom_range(0, regions.live_starts.size() - 1)];
        return $urandom_range(0, 3) == 0 ? 21'($urandom) : 21'($urandom_range(0, 4096));
    endfunction

    task automatic random_request();
        int sel;
        logic [20:0] amt;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       amt = 21'($urandom);
            1:       amt = 21'($urandom_range(0, 2));
            2:       amt = 21'($urandom_range(65536, MEM_BYTES));
            default: amt = 21'($urandom_range(1, 300));
        endcase
        if (sel < 45)      send_request(REQ_ALLOC, amt, 21'($urandom));
        else if (sel < 75) send_request(REQ_FREE, 21'($urandom), pick_start());
        else if (sel < 82) send_request(REQ_FREE_ABOVE, 21'($urandom), pick_start());
        else               send_request(REQ_QUERY, 21'($urandom), pick_start());
    endtask

    // Sink side: random wait per beat, plus one long hold-off.
    initial begin
        int wait_cycles;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end
            wait_cycles = $urandom_range(0, 16);
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            regions.check_result(m_tuser, m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        regions = new();
        regions.clear();
        hold_sink = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_ALLOC;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero size, whole memory, out of memory, frees, queries, table limits
        send_request(REQ_ALLOC, 21'd0, 21'h1FFFFF);
        send_request(REQ_QUERY, 21'h1FFFFF, 21'd0);
        send_request(REQ_ALLOC, 21'h1FFFFF, 21'd0);
        send_request(REQ_ALLOC, 21'(MEM_BYTES), 21'd0);
        send_request(REQ_ALLOC, 21'd1, 21'd0);
        send_request(REQ_QUERY, 21'd0, 21'd0);
        send_request(REQ_FREE, 21'd0, 21'd0);
        send_request(REQ_FREE, 21'd0, 21'd0);
        send_request(REQ_FREE_ABOVE, 21'd0, 21'h1FFFFF);
        for (int i = 0; i < 17; i++) send_request(REQ_ALLOC, 21'(i + 1), 21'd0);
        send_request(REQ_FREE_ABOVE, 21'd0, 21'd0);
        send_request(REQ_FREE_ABOVE, 21'd0, 21'd0);
        drain();

        // sink holds off while requests keep coming
        hold_sink = 1;
        for (int i = 0; i < 40; i++) random_request();
        drain();

        for (int i = 0; i < N_ITEMS; i++) begin
            random_request();
            if ($urandom_range(0, 199) == 0) drain();
        end
        drain();
        if (regions.errors == 0 && regions.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fra_pkg.sv
hw/rtl/fra_cell.sv
hw/rtl/fra_ring.sv
hw/rtl/first_fit_region_allocator.sv
hw/rtl/fra_check.sv
sim/tb_first_fit_region_allocator.sv
